// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL modules; tpd_parser includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/tpd_pkg.sv -----
// ----------------------------------------------------------------------------
// tpd_pkg
// Types, constants and helpers shared by the packet deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tpd_pkg;

    localparam int MaxTypes  = 16;
    localparam int TypeIdxW  = 4;
    localparam int CountW    = 5;
    localparam int DataW     = 64;
    localparam int AddrW     = 6;
    localparam int RegIdxW   = 3;

    // Register indexes on the configuration port (byte address = 8 * index).
    typedef enum logic [RegIdxW-1:0] {
        REG_START_CODE      = 3'd0,
        REG_TYPE_CODES_LOW  = 3'd1,
        REG_TYPE_CODES_HIGH = 3'd2,
        REG_LENGTHS_LOW     = 3'd3,
        REG_LENGTHS_HIGH    = 3'd4,
        REG_TYPE_COUNT      = 3'd5
    } t_reg_idx;

    // Parse phase, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TYPE = 4'b0010,
        PH_DATA = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0]        start_code;
        logic [DataW-1:0]  type_codes_low;
        logic [DataW-1:0]  type_codes_high;
        logic [DataW-1:0]  lengths_low;
        logic [DataW-1:0]  lengths_high;
        logic [CountW-1:0] type_count;
    } t_cfg;

    // Byte idx of a table split over two 64-bit registers.
    function automatic logic [7:0] byte_of(input logic [DataW-1:0] lo,
                                           input logic [DataW-1:0] hi,
                                           input logic [TypeIdxW-1:0] idx);
        logic [DataW-1:0] w;
        w = idx[3] ? hi : lo;
        return w[{idx[2:0], 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tpd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tpd_cfg_regs
// APB-style configuration registers: start code, type code table, length
// table and the number of valid types.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_cfg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tpd_pkg::AddrW-1:0]    paddr,
    input  wire logic [tpd_pkg::DataW-1:0]    pwdata,
    output logic      [tpd_pkg::DataW-1:0]    prdata,
    output logic                              pready,
    output tpd_pkg::t_cfg                     o_cfg
);

    tpd_pkg::t_cfg r_cfg;
    logic          w_wr;
    logic [tpd_pkg::RegIdxW-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[tpd_pkg::AddrW-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                tpd_pkg::REG_START_CODE:      r_cfg.start_code      <= pwdata[7:0];
                tpd_pkg::REG_TYPE_CODES_LOW:  r_cfg.type_codes_low  <= pwdata;
                tpd_pkg::REG_TYPE_CODES_HIGH: r_cfg.type_codes_high <= pwdata;
                tpd_pkg::REG_LENGTHS_LOW:     r_cfg.lengths_low     <= pwdata;
                tpd_pkg::REG_LENGTHS_HIGH:    r_cfg.lengths_high    <= pwdata;
                tpd_pkg::REG_TYPE_COUNT:
                    r_cfg.type_count <= pwdata[tpd_pkg::CountW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            tpd_pkg::REG_START_CODE:
                prdata = {{(tpd_pkg::DataW-8){1'b0}}, r_cfg.start_code};
            tpd_pkg::REG_TYPE_CODES_LOW:  prdata = r_cfg.type_codes_low;
            tpd_pkg::REG_TYPE_CODES_HIGH: prdata = r_cfg.type_codes_high;
            tpd_pkg::REG_LENGTHS_LOW:     prdata = r_cfg.lengths_low;
            tpd_pkg::REG_LENGTHS_HIGH:    prdata = r_cfg.lengths_high;
            tpd_pkg::REG_TYPE_COUNT:
                prdata = {{(tpd_pkg::DataW-tpd_pkg::CountW){1'b0}}, r_cfg.type_count};
            default: prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hw/rtl/tpd_parser.sv -----
// ----------------------------------------------------------------------------
// tpd_parser
// Input register, packet parse state and result register. One received byte
// is parsed per cycle while the result register is free or being taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tpd_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tpd_pkg::t_cfg i_cfg,
    input  wire logic          i_rx_valid,
    output logic               o_rx_ready,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [tpd_pkg::TypeIdxW-1:0] o_packet_type,
    output logic               o_carries_byte,
    output logic [7:0]         o_payload_byte,
    output logic               o_last
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Parse state.
    tpd_pkg::t_phase               r_phase, n_phase;
    logic [tpd_pkg::TypeIdxW-1:0]  r_cur_type, n_cur_type;
    logic [7:0]                    r_bytes_left, n_bytes_left;

    // Result register.
    logic                          r_out_valid;
    logic [tpd_pkg::TypeIdxW-1:0]  r_out_type;
    logic                          r_out_carries;
    logic [7:0]                    r_out_byte;
    logic                          r_out_last;

    logic                          w_adv;
    logic                          w_in_acc;
    logic                          w_res;
    logic [tpd_pkg::TypeIdxW-1:0]  w_res_type;
    logic                          w_res_carries;
    logic [7:0]                    w_res_byte;
    logic                          w_res_last;

    logic [tpd_pkg::CountW-1:0]    w_limit;
    logic [tpd_pkg::MaxTypes-1:0]  w_hit;
    logic                          w_found;
    logic [tpd_pkg::TypeIdxW-1:0]  w_hit_idx;
    logic [7:0]                    w_hit_len;

    // The parsed byte moves on whenever the result slot is free or draining.
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_rx_ready = !r_in_valid || w_adv;
    assign w_in_acc   = i_rx_valid && o_rx_ready;

    // Parallel type-code compare with lowest index winning.
    assign w_limit = (i_cfg.type_count > tpd_pkg::CountW'(tpd_pkg::MaxTypes))
                   ? tpd_pkg::CountW'(tpd_pkg::MaxTypes) : i_cfg.type_count;

    always_comb begin
        for (int k = 0; k < tpd_pkg::MaxTypes; k++) begin
            w_hit[k] = (tpd_pkg::byte_of(i_cfg.type_codes_low, i_cfg.type_codes_high,
                                         tpd_pkg::TypeIdxW'(k)) == r_in_byte)
                    && (tpd_pkg::CountW'(k) < w_limit);
        end
    end

    always_comb begin
        w_found   = 1'b0;
        w_hit_idx = '0;
        for (int k = tpd_pkg::MaxTypes - 1; k >= 0; k--) begin
            if (w_hit[k]) begin
                w_found   = 1'b1;
                w_hit_idx = tpd_pkg::TypeIdxW'(k);
            end
        end
    end

    assign w_hit_len = tpd_pkg::byte_of(i_cfg.lengths_low, i_cfg.lengths_high, w_hit_idx);

    always_comb begin
        n_phase       = r_phase;
        n_cur_type    = r_cur_type;
        n_bytes_left  = r_bytes_left;
        w_res         = 1'b0;
        w_res_type    = r_cur_type;
        w_res_carries = 1'b1;
        w_res_byte    = r_in_byte;
        w_res_last    = 1'b0;
        case (r_phase)
            tpd_pkg::PH_IDLE, tpd_pkg::PH_DONE: begin
                if (r_in_byte == i_cfg.start_code) begin
                    n_phase = tpd_pkg::PH_TYPE;
                end
            end
            tpd_pkg::PH_TYPE: begin
                if (!w_found) begin
                    n_phase      = tpd_pkg::PH_IDLE;
                    n_cur_type   = '0;
                    n_bytes_left = '0;
                end else begin
                    n_cur_type   = w_hit_idx;
                    n_bytes_left = w_hit_len;
                    if (w_hit_len == 8'd0) begin
                        // A zero-length type completes at once without data.
                        n_phase       = tpd_pkg::PH_DONE;
                        w_res         = 1'b1;
                        w_res_type    = w_hit_idx;
                        w_res_carries = 1'b0;
                        w_res_byte    = 8'd0;
                        w_res_last    = 1'b1;
                    end else begin
                        n_phase = tpd_pkg::PH_DATA;
                    end
                end
            end
            tpd_pkg::PH_DATA: begin
                w_res = 1'b1;
                if (r_bytes_left <= 8'd1) begin
                    n_bytes_left = '0;
                    n_phase      = tpd_pkg::PH_DONE;
                    w_res_last   = 1'b1;
                end else begin
                    n_bytes_left = r_bytes_left - 8'd1;
                end
            end
            default: begin
                n_phase = tpd_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_phase      <= tpd_pkg::PH_IDLE;
            r_cur_type   <= '0;
            r_bytes_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_phase      <= n_phase;
                r_cur_type   <= n_cur_type;
                r_bytes_left <= n_bytes_left;
            end
            if (w_adv && w_res) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_adv && w_res) begin
            r_out_type    <= w_res_type;
            r_out_carries <= w_res_carries;
            r_out_byte    <= w_res_byte;
            r_out_last    <= w_res_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_packet_type  = r_out_type;
    assign o_carries_byte = r_out_carries;
    assign o_payload_byte = r_out_byte;
    assign o_last         = r_out_last;

    `ASSERT_ALWAYS(a_phase_onehot, i_clk, i_rst_n, $onehot(r_phase))
    `ASSERT_IMPL(a_left_only_in_data, i_clk, i_rst_n, r_phase != tpd_pkg::PH_DATA, r_bytes_left == 8'd0)
    `ASSERT_NEXT(a_data_gives_result, i_clk, i_rst_n, w_adv && r_phase == tpd_pkg::PH_DATA, r_out_valid && r_out_carries)
    `ASSERT_NEXT(a_last_closes_packet, i_clk, i_rst_n, w_adv && w_res && w_res_last, r_phase == tpd_pkg::PH_DONE)

endmodule

`default_nettype wire

// ----- hw/rtl/typed_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// typed_packet_deframer
// Start-code / type / length packet deframer for a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter on the rx channel (i_rx_valid / o_rx_ready /
//   i_rx_byte), one transfer per byte. Each payload byte leaves on the out
//   channel (o_out_valid / i_out_ready) with its packet type and a last flag;
//   a zero-length type yields one result without data. Start and preamble
//   bytes produce no result, nor does a type byte of a non-zero length type.
//   The start code, type codes, lengths and type count are set over the APB
//   port (registers at byte addresses 0, 8, .. 40); the user must set them only
//   while the stream is idle, as the block itself does not enforce it.
//   A byte passes through the input register, then its result is written
//   to the result register, from which the out channel takes it.
//   Throughput: one byte per cycle while results are taken; the type lookup is
//   a parallel compare against the first type_count codes (at most sixteen) followed by a priority pick.
//   Reset (synchronous, active low) clears the configuration registers and the
//   valid and parse state, empties both stages and returns the parser to waiting for a start code.
//   When the receiver stalls, the result register holds, one byte waits in
//   the input register, and o_rx_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_packet_deframer (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [tpd_pkg::AddrW-1:0] paddr,
    input  wire logic [tpd_pkg::DataW-1:0] pwdata,
    output logic      [tpd_pkg::DataW-1:0] prdata,
    output logic                           pready,
    input  wire logic                      i_rx_valid,
    output logic                           o_rx_ready,
    input  wire logic [7:0]                i_rx_byte,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [3:0]                     o_packet_type,
    output logic                           o_carries_byte,
    output logic [7:0]                     o_payload_byte,
    output logic                           o_last
);

    tpd_pkg::t_cfg w_cfg;

    tpd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tpd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_packet_type  (o_packet_type),
        .o_carries_byte (o_carries_byte),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
